### sv/iss_pkg.sv
`default_nettype none
package iss_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 4;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int DATA_W   = 32;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_POS  = 2'd2;

  typedef logic signed [DATA_W-1:0] data_t;

  // per-cell update controls
  typedef struct packed {
    logic load;
    logic shift;
    logic valid;
  } iss_ctl_t;

  // running min/max handed down the chain
  typedef struct packed {
    logic  have;
    data_t mn;
    data_t mx;
  } iss_run_t;

endpackage
`default_nettype wire

### sv/iss_cell.sv
`default_nettype none
module iss_cell import iss_pkg::*; (
  input  wire logic     clk,
  input  wire iss_ctl_t ctl,
  input  wire data_t    in_value,
  input  wire data_t    next_elem,
  input  wire iss_run_t run_in,
  output data_t         elem,
  output logic          match,
  output iss_run_t      run_out
);

  data_t    elem_r, elem_nxt;
  iss_run_t run_r, run_nxt;

  // load a new entry, or take the upper neighbor's entry on a delete
  always_comb begin
    elem_nxt = elem_r;
    if (ctl.load) begin
      elem_nxt = in_value;
    end else if (ctl.shift) begin
      elem_nxt = next_elem;
    end
  end

  // fold this entry into the running min/max, or pass it through
  always_comb begin
    run_nxt = run_in;
    if (ctl.valid) begin
      if (run_in.have) begin
        run_nxt.mn = (elem_r < run_in.mn) ? elem_r : run_in.mn;
        run_nxt.mx = (elem_r > run_in.mx) ? elem_r : run_in.mx;
      end else begin
        run_nxt.have = 1'b1;
        run_nxt.mn   = elem_r;
        run_nxt.mx   = elem_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    elem_r <= elem_nxt;
    run_r  <= run_nxt;
  end

  assign elem    = elem_r;
  assign match   = ctl.valid && (elem_r == in_value);
  assign run_out = run_r;

endmodule
`default_nettype wire

### sv/integer_set_store.sv
`default_nettype none
// Result: strobed once the sweep counter, loaded at the edge that takes a command,
//   has counted down to zero, giving the min/max time to ripple down the cell chain.
// Commands: a new command is taken in the cycle the previous result is strobed, not before.
// Reset: synchronous active-low rst_n empties the set and idles the block; entries
//   are not cleared. Results cannot be stalled by the receiver.
module integer_set_store import iss_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_cmd,
  input  wire logic signed [31:0] in_value,
  input  wire logic [POS_W-1:0]  in_position,
  output logic                   out_strobe,
  output logic                   out_found,
  output logic [4:0]             out_count,
  output logic signed [31:0]     out_min_value,
  output logic signed [31:0]     out_max_value,
  output logic [1:0]             out_status
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_SWEEP = 1'b1;

  logic             state_r, state_nxt;
  logic [CNT_W-1:0] sweep_r, sweep_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             found_r, found_nxt;
  logic [1:0]       status_r, status_nxt;

  logic accept;
  logic hit;
  logic ins_ok;
  logic del_ok;

  iss_ctl_t         ctl_w  [CAPACITY];
  logic [CAPACITY-1:0] match_w;
  data_t            elem_w [CAPACITY+1];
  iss_run_t         run_w  [CAPACITY+1];
  logic [CNT_W+4:0] count_ext;

  // the block takes a word whenever no result is pending
  assign busy   = (state_r == ST_SWEEP) && (sweep_r != '0);
  assign accept = start && !busy;

  // membership from every cell at once
  assign hit    = |match_w;
  assign ins_ok = (in_cmd == CMD_INSERT) && !hit && (count_r != CNT_W'(CAPACITY));
  assign del_ok = (in_cmd == CMD_DELETE) &&
                  (CMP_W'(in_position) < CMP_W'(count_r));

  // head and tail of the chain
  assign run_w[0]         = '{have: 1'b0, mn: '0, mx: '0};
  assign elem_w[CAPACITY] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign ctl_w[i].valid = CNT_W'(i) < count_r;
    assign ctl_w[i].load  = accept && ins_ok && (CNT_W'(i) == count_r);
    assign ctl_w[i].shift = accept && del_ok && (CMP_W'(i) >= CMP_W'(in_position));

    iss_cell u_cell (
      .clk       (clk),
      .ctl       (ctl_w[i]),
      .in_value  (in_value),
      .next_elem (elem_w[i+1]),
      .run_in    (run_w[i]),
      .elem      (elem_w[i]),
      .match     (match_w[i]),
      .run_out   (run_w[i+1])
    );
  end

  // sweep countdown, command decode: set count, latch flag and status, restart the sweep
  always_comb begin
    state_nxt  = state_r;
    sweep_nxt  = sweep_r;
    count_nxt  = count_r;
    found_nxt  = found_r;
    status_nxt = status_r;
    if (state_r == ST_SWEEP && sweep_r != '0) begin
      sweep_nxt = sweep_r - 1'b1;
    end else if (state_r == ST_SWEEP) begin
      state_nxt = ST_IDLE;
    end
    if (accept) begin
      state_nxt  = ST_SWEEP;
      sweep_nxt  = CNT_W'(CAPACITY);
      found_nxt  = 1'b0;
      status_nxt = ST_OK;
      case (in_cmd)
        CMD_INSERT: begin
          found_nxt = hit;
          if (ins_ok) begin
            count_nxt = count_r + 1'b1;
          end else if (!hit) begin
            status_nxt = ST_FULL;
          end
        end
        CMD_DELETE: begin
          if (del_ok) begin
            count_nxt = count_r - 1'b1;
          end else begin
            status_nxt = ST_POS;
          end
        end
        CMD_QUERY: begin
          found_nxt = hit;
        end
        CMD_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sweep_r <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      sweep_r <= sweep_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    found_r  <= found_nxt;
    status_r <= status_nxt;
  end

  // the last cell holds min/max of the whole set once the sweep has run out
  assign count_ext     = {5'b0, count_r};
  assign out_strobe    = (state_r == ST_SWEEP) && (sweep_r == '0);
  assign out_found     = found_r;
  assign out_count     = count_ext[4:0];
  assign out_status    = status_r;
  assign out_min_value = run_w[CAPACITY].have ? run_w[CAPACITY].mn : '0;
  assign out_max_value = run_w[CAPACITY].have ? run_w[CAPACITY].mx : '0;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy && !out_strobe)
    else $error("no sweep after accepted word");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status == ST_FULL |-> count_r == CNT_W'(CAPACITY) && !out_found)
    else $error("full status with room left");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_found |-> out_status == ST_OK)
    else $error("found flag with error status");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && count_r == '0 |-> out_min_value == '0 && out_max_value == '0)
    else $error("empty set reports nonzero min/max");

endmodule
`default_nettype wire

### tb/tb_top.sv
module tb_top;
  import iss_pkg::*;

  // Idle cycles with neither a command taken nor a result strobed before giving up.
  // Each command waits out the sweep of the previous one, plus any idle stretch of the sender.
  localparam int STALL_LIMIT = 2000;
  localparam int WORDS_TOTAL = 1650;
  // Episodes that start in the closing stretch of the run keep the sender busy with no gaps.
  localparam int QUIET_TAIL  = 200;

  // One result word as the block reports it.
  typedef struct packed {
    logic       found;
    logic [4:0] count;
    data_t      min_value;
    data_t      max_value;
    logic [1:0] status;
  } set_word_t;

  // Mirror of the set contents. Predicts the result word for every command
  // taken and checks the words that come back, in order.
  class set_mirror;
    data_t       members[CAPACITY];
    int          size;
    set_word_t   expected_words[$];
    int          errors;

    function bit holds(data_t v);
      int i;
      for (i = 0; i < size; i++)
        if (members[i] == v) return 1'b1;
      return 1'b0;
    endfunction

    function void take_command(logic [1:0] cmd, data_t value, logic [POS_W-1:0] pos);
      set_word_t w;
      int        i;
      w = '0;
      case (cmd)
        CMD_INSERT: begin
          if (holds(value)) begin
            w.found = 1'b1;
          end else if (size >= CAPACITY) begin
            w.status = ST_FULL;
          end else begin
            members[size] = value;
            size++;
          end
        end
        CMD_DELETE: begin
          if (int'(pos) >= size) begin
            w.status = ST_POS;
          end else begin
            for (i = int'(pos); i + 1 < size; i++)
              members[i] = members[i+1];
            size--;
          end
        end
        CMD_QUERY: begin
          w.found = holds(value);
        end
        default: begin
          size = 0;
        end
      endcase
      if (size > 0) begin
        w.min_value = members[0];
        w.max_value = members[0];
        for (i = 1; i < size; i++) begin
          if (members[i] < w.min_value) w.min_value = members[i];
          if (members[i] > w.max_value) w.max_value = members[i];
        end
      end
      w.count = 5'(size);
      expected_words.push_back(w);
    endfunction

    function void match_result(set_word_t got);
      set_word_t want;
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result with no command pending: found=%0b count=%0d min=%0d max=%0d st=%0d",
                   $realtime, got.found, got.count, got.min_value, got.max_value, got.status);
        return;
      end
      want = expected_words.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: result mismatch", $realtime);
          $display("  expected found=%0b count=%0d min=%0d max=%0d st=%0d",
                   want.found, want.count, want.min_value, want.max_value, want.status);
          $display("  actual   found=%0b count=%0d min=%0d max=%0d st=%0d",
                   got.found, got.count, got.min_value, got.max_value, got.status);
        end
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic [1:0]       in_cmd = CMD_QUERY;
  logic signed [31:0] in_value = '0;
  logic [POS_W-1:0] in_position = '0;
  wire              busy;
  wire              out_strobe;
  wire              out_found;
  wire [4:0]        out_count;
  wire signed [31:0] out_min_value;
  wire signed [31:0] out_max_value;
  wire [1:0]        out_status;

  set_mirror mirror = new;
  int        words_sent = 0;
  bit        idle_enable = 1'b0;
  int        quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  integer_set_store dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_cmd       (in_cmd),
    .in_value     (in_value),
    .in_position  (in_position),
    .out_strobe   (out_strobe),
    .out_found    (out_found),
    .out_count    (out_count),
    .out_min_value(out_min_value),
    .out_max_value(out_max_value),
    .out_status   (out_status)
  );

  // Results cannot be held off: take every strobed word at the edge that ends it.
  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1)
      mirror.match_result({out_found, out_count, out_min_value, out_max_value, out_status});
  end

  // Watchdog: count edges where nothing moves on either side.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && busy === 1'b0) || out_strobe === 1'b1) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Present one command word and hold it until the block takes it. Returns at the
  // accepting edge with start still high, so the next word can follow back to back.
  task automatic send_word(logic [1:0] cmd, data_t value, logic [POS_W-1:0] pos);
    in_cmd      <= cmd;
    in_value    <= value;
    in_position <= pos;
    start       <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    mirror.take_command(cmd, value, pos);
    words_sent++;
  endtask

  // Drop start for a burst of cycles; scramble the idle fields while at it.
  task automatic hold_off(int cycles);
    start       <= 1'b0;
    in_cmd      <= 2'($urandom);
    in_value    <= $urandom;
    in_position <= POS_W'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  task automatic maybe_idle();
    if (idle_enable && $urandom_range(3) == 0)
      hold_off($urandom_range(1, 10));
  endtask

  // Values: half or more are members or a small pool of corner values, so duplicates
  // and hits happen often; the rest fully random to toggle every bit.
  function automatic data_t pick_value(int member_pct);
    int r;
    r = $urandom_range(99);
    if (r < member_pct && mirror.size > 0)
      return mirror.members[$urandom_range(mirror.size - 1)];
    if (r < member_pct + 30) begin
      case ($urandom_range(4))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7fff_ffff;
        2:       return -32'sd1;
        default: return data_t'($signed($urandom_range(8))) - 32'sd4;
      endcase
    end
    return data_t'($urandom);
  endfunction

  // One command from an episode profile: percent of inserts, queries, deletes;
  // the remainder are clears. About one word in ten is noise with random fields.
  task automatic random_word(int ins_pct, int qry_pct, int del_pct);
    int               r;
    logic [POS_W-1:0] pos;
    r = $urandom_range(99);
    if ($urandom_range(9) == 0) begin
      // noise: anything the fields allow
      send_word(2'($urandom), data_t'($urandom), POS_W'($urandom));
    end else if (r < ins_pct) begin
      send_word(CMD_INSERT, pick_value(20), POS_W'($urandom));
    end else if (r < ins_pct + qry_pct) begin
      send_word(CMD_QUERY, pick_value(50), POS_W'($urandom));
    end else if (r < ins_pct + qry_pct + del_pct) begin
      // mostly valid positions, now and then anywhere
      if (mirror.size > 0 && $urandom_range(4) != 0)
        pos = POS_W'($urandom_range(mirror.size - 1));
      else
        pos = POS_W'($urandom);
      send_word(CMD_DELETE, data_t'($urandom), pos);
    end else begin
      send_word(CMD_CLEAR, data_t'($urandom), POS_W'($urandom));
    end
  endtask

  initial begin
    int i;
    int kind;
    int span;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty set, extremes, duplicate insert, range errors, shift on delete.
    send_word(CMD_QUERY,  32'sd0,            4'd0);
    send_word(CMD_DELETE, 32'sd0,            4'd0);
    send_word(CMD_INSERT, 32'sh8000_0000,    4'd0);
    send_word(CMD_INSERT, 32'sh7fff_ffff,    4'd0);
    send_word(CMD_INSERT, 32'sh8000_0000,    4'd0);
    send_word(CMD_QUERY,  32'sh7fff_ffff,    4'd0);
    send_word(CMD_DELETE, 32'sd0,            4'd2);
    send_word(CMD_DELETE, 32'sd0,            4'd0);
    send_word(CMD_CLEAR,  32'sd0,            4'd0);
    // Fill to capacity, then push one more and drop the last entry.
    for (i = 0; i < CAPACITY; i++)
      send_word(CMD_INSERT, data_t'(i) - 32'sd8, 4'd0);
    send_word(CMD_INSERT, 32'sd100,          4'd0);
    send_word(CMD_DELETE, 32'sd0,            4'(CAPACITY - 1));

    // Random episodes with different command mixes; fill-heavy ones keep the
    // set near full so dropped inserts show up regularly.
    while (words_sent < WORDS_TOTAL) begin
      kind = $urandom_range(3);
      span = $urandom_range(10, 40);
      idle_enable = (words_sent < WORDS_TOTAL - QUIET_TAIL) && ($urandom_range(2) != 0);
      for (i = 0; i < span && words_sent < WORDS_TOTAL; i++) begin
        case (kind)
          0:       random_word(70, 15, 12);
          1:       random_word(40, 25, 32);
          2:       random_word(15, 20, 62);
          default: random_word(25, 55, 17);
        endcase
        maybe_idle();
      end
      if ($urandom_range(2) == 0 && words_sent < WORDS_TOTAL) begin
        send_word(CMD_CLEAR, data_t'($urandom), POS_W'($urandom));
        maybe_idle();
      end
    end

    // Drain: wait out every pending result, then catch any stray strobe after it.
    start <= 1'b0;
    while (mirror.expected_words.size() != 0) @(posedge clk);
    repeat (CAPACITY + 4) @(posedge clk);
    if (mirror.errors == 0 && mirror.expected_words.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
